// ----- hdl/i2cm_pkg.sv -----
package i2cm_pkg;

    // Configuration port geometry
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Register map
    localparam logic [APB_ADDR_W-1:0] REG_DELAY_ADDR = 2'd0;

    // Bus timing
    localparam int DELAY_W = 16;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd5;
    localparam logic [DELAY_W-1:0] DELAY_MIN = 16'd1;

    // Byte handling
    localparam int BYTE_W = 8;
    localparam int BIT_CNT_W = 4;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [BYTE_W-1:0] ADDR_NACK_FILL = 8'hFF;

    // Transaction status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ADDR_NACK = 2'd1,
        STATUS_DATA_NACK = 2'd2
    } status_t;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

endpackage

// ----- hdl/i2c_master_byte_transaction_core.sv -----
// I2C master that runs one single-byte write or read transaction at a time.
// Input channel (in_valid / in_stall): each request is one timing tick and
// carries an optional command (cmd_valid, op, dev_addr, wr_data, send_ack)
// plus the sampled SDA level. A command is taken only while idle; while a
// transaction runs, commands are ignored.
// Output channel (out_valid / out_stall): every request yields exactly one
// result with the SCL and SDA levels for that tick, busy_res, and done_res
// together with status and rd_data on the final tick of a transaction.
// Each accepted request loads the result register; one request is accepted
// every cycle unless a held result stalls. The sequencer state lies one
// logic level from that register, which alone sets the rate.
// When the receiver stalls while a result is held, in_stall rises and the
// held result stays unchanged until it is taken.
// The APB port holds one register, delay_ticks, at address 0: the number
// of ticks each bus delay lasts. Write it only while the block is idle.
// Reset returns the bus to idle (SCL and SDA high), empties the result
// register and sets delay_ticks to 5.
module i2c_master_byte_transaction_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd_valid,
    input  logic                          op,
    input  logic [7:0]                    dev_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          send_ack,
    input  logic                          sda_in,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          scl,
    output logic                          sda_out,
    output logic                          busy_res,
    output logic                          done_res,
    output logic [1:0]                    status,
    output logic [7:0]                    rd_data,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [i2cm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [i2cm_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_SDA1,
        PH_ST_SCL1,
        PH_ST_SDA0,
        PH_ST_DLY,
        PH_ST_SCL0,
        PH_WB_SDA,
        PH_WB_D1,
        PH_WB_SCLH,
        PH_WB_D2,
        PH_WB_SCLL,
        PH_WA_SDA1,
        PH_WA_SCLH,
        PH_WA_DLY,
        PH_WA_SCLL,
        PH_RB_SDA1,
        PH_RB_SCLH,
        PH_RB_DLY,
        PH_RB_SCLL,
        PH_RA_SDA,
        PH_RA_D1,
        PH_RA_SCLH,
        PH_RA_D2,
        PH_RA_SCLL,
        PH_SP_SCL0,
        PH_SP_SDA0,
        PH_SP_DLY,
        PH_SP_SCLH,
        PH_SP_SDA1
    } phase_t;

    // Sequencer state
    phase_t                 phase_reg, phase_next;
    logic [BIT_CNT_W-1:0]   bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    logic [DELAY_W-1:0]     wait_count_reg, wait_count_next;
    logic                   scl_level_reg, scl_level_next;
    logic                   sda_level_reg, sda_level_next;
    logic                   cmd_op_reg, cmd_op_next;
    logic [BYTE_W-1:0]      cmd_addr_reg, cmd_addr_next;
    logic [BYTE_W-1:0]      cmd_data_reg, cmd_data_next;
    logic                   cmd_ack_reg, cmd_ack_next;
    logic                   byte_stage_reg, byte_stage_next;
    logic                   nack_seen_reg, nack_seen_next;
    status_t                final_status_reg, final_status_next;

    // Configuration
    logic [DELAY_W-1:0]     delay_reg;

    // Result register
    logic                   out_valid_reg;
    logic                   scl_reg;
    logic                   sda_out_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [1:0]             status_reg;
    logic [BYTE_W-1:0]      rd_data_reg;

    // Per-tick combinational results
    logic                   busy_next;
    logic                   done_next;
    status_t                status_next;
    logic [BYTE_W-1:0]      rd_data_next;

    logic                   accept;
    logic                   cfg_write;
    logic [DELAY_W-1:0]     delay_limit;
    logic [DELAY_W-1:0]     wait_inc;
    logic                   delay_end;
    logic [BIT_CNT_W-1:0]   bit_inc;

    // Handshakes
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr == REG_DELAY_ADDR);

    // Register read-back
    always_comb
    begin
        if (paddr == REG_DELAY_ADDR)
        begin
            prdata = {{(APB_DATA_W-DELAY_W){1'b0}}, delay_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Delay counter step; a zero delay acts as one tick.
    assign delay_limit = (delay_reg == '0) ? DELAY_MIN : delay_reg;
    assign wait_inc    = wait_count_reg + DELAY_MIN;
    assign delay_end   = (wait_inc >= delay_limit);
    assign bit_inc     = bit_count_reg + 1'b1;

    // Sequencer: one step per request
    always_comb
    begin
        phase_t ph;

        ph                = phase_reg;
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_next        = shift_reg;
        wait_count_next   = wait_count_reg;
        scl_level_next    = scl_level_reg;
        sda_level_next    = sda_level_reg;
        cmd_op_next       = cmd_op_reg;
        cmd_addr_next     = cmd_addr_reg;
        cmd_data_next     = cmd_data_reg;
        cmd_ack_next      = cmd_ack_reg;
        byte_stage_next   = byte_stage_reg;
        nack_seen_next    = nack_seen_reg;
        final_status_next = final_status_reg;
        busy_next         = 1'b1;
        done_next         = 1'b0;
        status_next       = STATUS_OK;
        rd_data_next      = '0;

        // Latch a new command when idle; it starts driving on this tick.
        if (phase_reg == PH_IDLE)
        begin
            if (cmd_valid)
            begin
                cmd_op_next       = op;
                cmd_addr_next     = dev_addr;
                cmd_data_next     = wr_data;
                cmd_ack_next      = send_ack;
                byte_stage_next   = 1'b0;
                nack_seen_next    = 1'b0;
                final_status_next = STATUS_OK;
                wait_count_next   = '0;
                ph                = PH_ST_SDA1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end

        case (ph)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            // Start condition
            PH_ST_SDA1:
            begin
                sda_level_next = 1'b1;
                phase_next     = PH_ST_SCL1;
            end
            PH_ST_SCL1:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_ST_SDA0;
            end
            PH_ST_SDA0:
            begin
                sda_level_next = 1'b0;
                phase_next     = PH_ST_DLY;
            end
            PH_ST_DLY:
            begin
                wait_count_next = delay_end ? '0 : wait_inc;
                phase_next      = delay_end ? PH_ST_SCL0 : PH_ST_DLY;
            end
            PH_ST_SCL0:
            begin
                scl_level_next = 1'b0;
                shift_next     = cmd_addr_reg;
                bit_count_next = '0;
                phase_next     = PH_WB_SDA;
            end
            // Byte transmit, MSB first
            PH_WB_SDA:
            begin
                sda_level_next = shift_reg[BYTE_W-1];
                phase_next     = PH_WB_D1;
            end
            PH_WB_D1:
            begin
                wait_count_next = delay_end ? '0 : wait_inc;
                phase_next      = delay_end ? PH_WB_SCLH : PH_WB_D1;
            end
            PH_WB_SCLH:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_WB_D2;
            end
            PH_WB_D2:
            begin
                wait_count_next = delay_end ? '0 : wait_inc;
                phase_next      = delay_end ? PH_WB_SCLL : PH_WB_D2;
            end
            PH_WB_SCLL:
            begin
                scl_level_next = 1'b0;
                shift_next     = {shift_reg[BYTE_W-2:0], 1'b0};
                bit_count_next = bit_inc;
                phase_next     = (bit_inc >= BITS_PER_BYTE) ? PH_WA_SDA1 : PH_WB_SDA;
            end
            // Acknowledge check from the slave
            PH_WA_SDA1:
            begin
                sda_level_next = 1'b1;
                phase_next     = PH_WA_SCLH;
            end
            PH_WA_SCLH:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_WA_DLY;
            end
            PH_WA_DLY:
            begin
                wait_count_next = delay_end ? '0 : wait_inc;
                if (delay_end)
                begin
                    nack_seen_next = sda_in;
                    phase_next     = PH_WA_SCLL;
                end
            end
            PH_WA_SCLL:
            begin
                scl_level_next = 1'b0;
                bit_count_next = '0;
                if (nack_seen_reg)
                begin
                    final_status_next = byte_stage_reg ? STATUS_DATA_NACK
                                                       : STATUS_ADDR_NACK;
                    if (cmd_op_reg == OP_READ)
                    begin
                        shift_next = ADDR_NACK_FILL;
                    end
                    phase_next = PH_SP_SCL0;
                end
                else if (!byte_stage_reg)
                begin
                    byte_stage_next = 1'b1;
                    if (cmd_op_reg == OP_READ)
                    begin
                        shift_next = '0;
                        phase_next = PH_RB_SDA1;
                    end
                    else
                    begin
                        shift_next = cmd_data_reg;
                        phase_next = PH_WB_SDA;
                    end
                end
                else
                begin
                    phase_next = PH_SP_SCL0;
                end
            end
            // Byte receive, sampled at the end of the high delay
            PH_RB_SDA1:
            begin
                sda_level_next = 1'b1;
                phase_next     = PH_RB_SCLH;
            end
            PH_RB_SCLH:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_RB_DLY;
            end
            PH_RB_DLY:
            begin
                wait_count_next = delay_end ? '0 : wait_inc;
                if (delay_end)
                begin
                    shift_next = {shift_reg[BYTE_W-2:0], sda_in};
                    phase_next = PH_RB_SCLL;
                end
            end
            PH_RB_SCLL:
            begin
                scl_level_next = 1'b0;
                bit_count_next = bit_inc;
                phase_next     = (bit_inc >= BITS_PER_BYTE) ? PH_RA_SDA : PH_RB_SCLH;
            end
            // Master ACK or NACK after a read
            PH_RA_SDA:
            begin
                sda_level_next = ~cmd_ack_reg;
                phase_next     = PH_RA_D1;
            end
            PH_RA_D1:
            begin
                wait_count_next = delay_end ? '0 : wait_inc;
                phase_next      = delay_end ? PH_RA_SCLH : PH_RA_D1;
            end
            PH_RA_SCLH:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_RA_D2;
            end
            PH_RA_D2:
            begin
                wait_count_next = delay_end ? '0 : wait_inc;
                phase_next      = delay_end ? PH_RA_SCLL : PH_RA_D2;
            end
            PH_RA_SCLL:
            begin
                scl_level_next = 1'b0;
                phase_next     = PH_SP_SCL0;
            end
            // Stop condition
            PH_SP_SCL0:
            begin
                scl_level_next = 1'b0;
                phase_next     = PH_SP_SDA0;
            end
            PH_SP_SDA0:
            begin
                sda_level_next = 1'b0;
                phase_next     = PH_SP_DLY;
            end
            PH_SP_DLY:
            begin
                wait_count_next = delay_end ? '0 : wait_inc;
                phase_next      = delay_end ? PH_SP_SCLH : PH_SP_DLY;
            end
            PH_SP_SCLH:
            begin
                scl_level_next = 1'b1;
                phase_next     = PH_SP_SDA1;
            end
            PH_SP_SDA1:
            begin
                sda_level_next = 1'b1;
                done_next      = 1'b1;
                status_next    = final_status_reg;
                rd_data_next   = (cmd_op_reg == OP_READ) ? shift_reg : '0;
                phase_next     = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // State, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            shift_reg        <= '0;
            wait_count_reg   <= '0;
            scl_level_reg    <= 1'b1;
            sda_level_reg    <= 1'b1;
            cmd_op_reg       <= 1'b0;
            cmd_addr_reg     <= '0;
            cmd_data_reg     <= '0;
            cmd_ack_reg      <= 1'b0;
            byte_stage_reg   <= 1'b0;
            nack_seen_reg    <= 1'b0;
            final_status_reg <= STATUS_OK;
            delay_reg        <= DELAY_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                delay_reg <= pwdata[DELAY_W-1:0];
            end

            if (accept)
            begin
                phase_reg        <= phase_next;
                bit_count_reg    <= bit_count_next;
                shift_reg        <= shift_next;
                wait_count_reg   <= wait_count_next;
                scl_level_reg    <= scl_level_next;
                sda_level_reg    <= sda_level_next;
                cmd_op_reg       <= cmd_op_next;
                cmd_addr_reg     <= cmd_addr_next;
                cmd_data_reg     <= cmd_data_next;
                cmd_ack_reg      <= cmd_ack_next;
                byte_stage_reg   <= byte_stage_next;
                nack_seen_reg    <= nack_seen_next;
                final_status_reg <= final_status_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_reg     <= scl_level_next;
            sda_out_reg <= sda_level_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            rd_data_reg <= rd_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl       = scl_reg;
    assign sda_out   = sda_out_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign status    = status_reg;
    assign rd_data   = rd_data_reg;

endmodule

// ----- dv/tb.sv -----
module tb;
    import i2cm_pkg::*;

    // Sequencer steps of the bus master, one per pin change or delay.
    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_START_SDA_HI,
        SEQ_START_SCL_HI,
        SEQ_START_SDA_LO,
        SEQ_START_WAIT,
        SEQ_START_SCL_LO,
        SEQ_TX_SDA,
        SEQ_TX_SETUP,
        SEQ_TX_SCL_HI,
        SEQ_TX_HOLD,
        SEQ_TX_SCL_LO,
        SEQ_TXACK_SDA_HI,
        SEQ_TXACK_SCL_HI,
        SEQ_TXACK_WAIT,
        SEQ_TXACK_SCL_LO,
        SEQ_RX_SDA_HI,
        SEQ_RX_SCL_HI,
        SEQ_RX_WAIT,
        SEQ_RX_SCL_LO,
        SEQ_RXACK_SDA,
        SEQ_RXACK_SETUP,
        SEQ_RXACK_SCL_HI,
        SEQ_RXACK_HOLD,
        SEQ_RXACK_SCL_LO,
        SEQ_STOP_SCL_LO,
        SEQ_STOP_SDA_LO,
        SEQ_STOP_WAIT,
        SEQ_STOP_SCL_HI,
        SEQ_STOP_SDA_HI
    } bus_phase_t;

    // Levels and flags reported for one tick.
    typedef struct packed {
        logic          scl;
        logic          sda;
        logic          busy;
        logic          done;
        status_t       status;
        logic [7:0]    rd;
    } bus_levels_t;

    // One line of stimulus: a transaction with the slave's answers, or a run
    // of idle ticks.
    typedef struct packed {
        logic          is_cmd;
        logic          op;
        logic [7:0]    addr;
        logic [7:0]    data;
        logic          ack;
        logic          addr_nak;
        logic          data_nak;
        logic [7:0]    slave_byte;
        logic [7:0]    idle_ticks;
        logic          typed;
        status_t       t_status;
        logic [7:0]    t_rd;
    } plan_t;

    localparam bus_levels_t BUS_RELEASED = {1'b1, 1'b1, 1'b0, 1'b0, STATUS_OK, 8'h00};
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int DIRECTED_ROWS = 6;
    localparam int RANDOM_PHASES = 2;
    localparam logic [1:0][15:0] PHASE_DELAY = {16'd2, 16'd0};
    localparam logic [1:0][7:0] PHASE_TXNS = {8'd1, 8'd1};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd_valid = 1'b0;
    logic op = 1'b0;
    logic [7:0] dev_addr = 8'h00;
    logic [7:0] wr_data = 8'h00;
    logic send_ack = 1'b0;
    logic sda_in = 1'b1;

    logic out_valid;
    logic out_stall = 1'b0;
    logic scl;
    logic sda_out;
    logic busy_res;
    logic done_res;
    logic [1:0] status;
    logic [7:0] rd_data;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Directed transactions, run with a one-tick bus delay.
    // is_cmd op addr data ack addr_nak data_nak slave_byte idle typed status rd
    plan_t directed_plan [DIRECTED_ROWS] = '{
        '{1'b0, OP_WRITE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'd4, 1'b1, STATUS_OK, 8'h00},
        '{1'b1, OP_WRITE, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 8'hFF, 8'd0, 1'b1, STATUS_OK, 8'h00},
        '{1'b1, OP_WRITE, 8'h3C, 8'hC3, 1'b1, 1'b0, 1'b1, 8'h00, 8'd0, 1'b1,
          STATUS_DATA_NACK, 8'h00},
        '{1'b1, OP_READ, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 8'hA5, 8'd0, 1'b1, STATUS_OK, 8'hA5},
        '{1'b1, OP_READ, 8'h6B, 8'h00, 1'b1, 1'b1, 1'b0, 8'h3C, 8'd0, 1'b1,
          STATUS_ADDR_NACK, 8'hFF},
        '{1'b0, OP_WRITE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'd3, 1'b1, STATUS_OK, 8'h00}
    };

    // Predicted master state.
    bus_phase_t bus_phase = SEQ_IDLE;
    logic [15:0] bus_delay = DELAY_RESET;
    logic [3:0] bit_cnt = '0;
    logic [7:0] shreg = '0;
    logic [15:0] wait_cnt = '0;
    logic scl_lvl = 1'b1;
    logic sda_lvl = 1'b1;
    logic cmd_op = 1'b0;
    logic [7:0] cmd_addr = '0;
    logic [7:0] cmd_data = '0;
    logic cmd_ack = 1'b0;
    logic data_stage = 1'b0;
    logic nack_seen = 1'b0;
    status_t fin_status = STATUS_OK;

    bus_levels_t expected_levels_q [$];

    int error_count = 0;
    int results_seen = 0;
    int ticks_sent = 0;
    int cycle_count = 0;
    int n_done = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_addr_nak = 0;
    int n_data_nak = 0;
    int long_hold_requests = 0;
    bit sender_quiet = 1'b0;
    bit pause_mid_txn = 1'b0;

    i2c_master_byte_transaction_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd_valid (cmd_valid),
        .op        (op),
        .dev_addr  (dev_addr),
        .wr_data   (wr_data),
        .send_ack  (send_ack),
        .sda_in    (sda_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .scl       (scl),
        .sda_out   (sda_out),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .status    (status),
        .rd_data   (rd_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, results_seen, got, want);
        error_count++;
    endtask

    // Counts one delay tick; true on the last tick of the delay.
    function automatic bit bus_wait_over();
        logic [15:0] lim;
        lim = (bus_delay == 16'd0) ? DELAY_MIN : bus_delay;
        wait_cnt = wait_cnt + 16'd1;
        if (wait_cnt >= lim)
        begin
            wait_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the predicted master by one tick and gives the levels it drives.
    task automatic bus_step(input logic cv, input logic opv, input logic [7:0] av,
                            input logic [7:0] dv, input logic ackv, input logic sdav,
                            output bus_levels_t r);
        r.busy = 1'b1;
        r.done = 1'b0;
        r.status = STATUS_OK;
        r.rd = 8'h00;
        if (bus_phase == SEQ_IDLE)
        begin
            if (cv)
            begin
                cmd_op = opv;
                cmd_addr = av;
                cmd_data = dv;
                cmd_ack = ackv;
                data_stage = 1'b0;
                nack_seen = 1'b0;
                fin_status = STATUS_OK;
                wait_cnt = '0;
                bus_phase = SEQ_START_SDA_HI;
            end
            else
            begin
                r.busy = 1'b0;
            end
        end

        case (bus_phase)
            SEQ_IDLE: ;
            SEQ_START_SDA_HI:
            begin
                sda_lvl = 1'b1;
                bus_phase = SEQ_START_SCL_HI;
            end
            SEQ_START_SCL_HI:
            begin
                scl_lvl = 1'b1;
                bus_phase = SEQ_START_SDA_LO;
            end
            SEQ_START_SDA_LO:
            begin
                sda_lvl = 1'b0;
                bus_phase = SEQ_START_WAIT;
            end
            SEQ_START_WAIT:
            begin
                if (bus_wait_over())
                    bus_phase = SEQ_START_SCL_LO;
            end
            SEQ_START_SCL_LO:
            begin
                scl_lvl = 1'b0;
                shreg = cmd_addr;
                bit_cnt = '0;
                bus_phase = SEQ_TX_SDA;
            end
            SEQ_TX_SDA:
            begin
                sda_lvl = shreg[7];
                bus_phase = SEQ_TX_SETUP;
            end
            SEQ_TX_SETUP:
            begin
                if (bus_wait_over())
                    bus_phase = SEQ_TX_SCL_HI;
            end
            SEQ_TX_SCL_HI:
            begin
                scl_lvl = 1'b1;
                bus_phase = SEQ_TX_HOLD;
            end
            SEQ_TX_HOLD:
            begin
                if (bus_wait_over())
                    bus_phase = SEQ_TX_SCL_LO;
            end
            SEQ_TX_SCL_LO:
            begin
                scl_lvl = 1'b0;
                shreg = {shreg[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                bus_phase = (bit_cnt >= BITS_PER_BYTE) ? SEQ_TXACK_SDA_HI : SEQ_TX_SDA;
            end
            SEQ_TXACK_SDA_HI:
            begin
                sda_lvl = 1'b1;
                bus_phase = SEQ_TXACK_SCL_HI;
            end
            SEQ_TXACK_SCL_HI:
            begin
                scl_lvl = 1'b1;
                bus_phase = SEQ_TXACK_WAIT;
            end
            SEQ_TXACK_WAIT:
            begin
                if (bus_wait_over())
                begin
                    nack_seen = sdav;
                    bus_phase = SEQ_TXACK_SCL_LO;
                end
            end
            SEQ_TXACK_SCL_LO:
            begin
                // The slave's answer decides between abort, next byte and stop.
                scl_lvl = 1'b0;
                bit_cnt = '0;
                if (nack_seen)
                begin
                    fin_status = data_stage ? STATUS_DATA_NACK : STATUS_ADDR_NACK;
                    if (cmd_op == OP_READ)
                        shreg = ADDR_NACK_FILL;
                    bus_phase = SEQ_STOP_SCL_LO;
                end
                else if (!data_stage)
                begin
                    data_stage = 1'b1;
                    if (cmd_op == OP_READ)
                    begin
                        shreg = 8'h00;
                        bus_phase = SEQ_RX_SDA_HI;
                    end
                    else
                    begin
                        shreg = cmd_data;
                        bus_phase = SEQ_TX_SDA;
                    end
                end
                else
                begin
                    bus_phase = SEQ_STOP_SCL_LO;
                end
            end
            SEQ_RX_SDA_HI:
            begin
                sda_lvl = 1'b1;
                bus_phase = SEQ_RX_SCL_HI;
            end
            SEQ_RX_SCL_HI:
            begin
                scl_lvl = 1'b1;
                bus_phase = SEQ_RX_WAIT;
            end
            SEQ_RX_WAIT:
            begin
                if (bus_wait_over())
                begin
                    shreg = {shreg[6:0], sdav};
                    bus_phase = SEQ_RX_SCL_LO;
                end
            end
            SEQ_RX_SCL_LO:
            begin
                scl_lvl = 1'b0;
                bit_cnt = bit_cnt + 4'd1;
                bus_phase = (bit_cnt >= BITS_PER_BYTE) ? SEQ_RXACK_SDA : SEQ_RX_SCL_HI;
            end
            SEQ_RXACK_SDA:
            begin
                sda_lvl = !cmd_ack;
                bus_phase = SEQ_RXACK_SETUP;
            end
            SEQ_RXACK_SETUP:
            begin
                if (bus_wait_over())
                    bus_phase = SEQ_RXACK_SCL_HI;
            end
            SEQ_RXACK_SCL_HI:
            begin
                scl_lvl = 1'b1;
                bus_phase = SEQ_RXACK_HOLD;
            end
            SEQ_RXACK_HOLD:
            begin
                if (bus_wait_over())
                    bus_phase = SEQ_RXACK_SCL_LO;
            end
            SEQ_RXACK_SCL_LO:
            begin
                scl_lvl = 1'b0;
                bus_phase = SEQ_STOP_SCL_LO;
            end
            SEQ_STOP_SCL_LO:
            begin
                scl_lvl = 1'b0;
                bus_phase = SEQ_STOP_SDA_LO;
            end
            SEQ_STOP_SDA_LO:
            begin
                sda_lvl = 1'b0;
                bus_phase = SEQ_STOP_WAIT;
            end
            SEQ_STOP_WAIT:
            begin
                if (bus_wait_over())
                    bus_phase = SEQ_STOP_SCL_HI;
            end
            SEQ_STOP_SCL_HI:
            begin
                scl_lvl = 1'b1;
                bus_phase = SEQ_STOP_SDA_HI;
            end
            default:
            begin
                // The stop's SDA rise ends the transaction.
                sda_lvl = 1'b1;
                r.done = 1'b1;
                r.status = fin_status;
                r.rd = (cmd_op == OP_READ) ? shreg : 8'h00;
                bus_phase = SEQ_IDLE;
            end
        endcase
        r.scl = scl_lvl;
        r.sda = sda_lvl;
    endtask

    // Slave side of the bus: the planned answer on the sampling tick of an
    // acknowledge or read bit, noise on every other tick.
    function automatic logic slave_sda(input plan_t p);
        logic [15:0] lim;
        logic [15:0] nxt;
        logic last;
        lim = (bus_delay == 16'd0) ? DELAY_MIN : bus_delay;
        nxt = wait_cnt + 16'd1;
        last = (nxt >= lim);
        if (last && bus_phase == SEQ_TXACK_WAIT)
            return data_stage ? p.data_nak : p.addr_nak;
        if (last && bus_phase == SEQ_RX_WAIT)
            return p.slave_byte[3'd7 - bit_cnt[2:0]];
        return ($urandom_range(0, 1) == 1);
    endfunction

    // Offers one request after a random gap, waits for it to be taken, and
    // predicts what it causes.
    task automatic send_tick(input logic cv, input logic opv, input logic [7:0] av,
                             input logic [7:0] dv, input logic ackv, input logic sdav,
                             output bus_levels_t r);
        int gap;
        int pick;
        if (ticks_sent % 256 == 0)
            sender_quiet = ($urandom_range(0, 3) == 0);
        gap = 0;
        if (!sender_quiet)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 98)
                gap = $urandom_range(20, 60);
            else if (pick >= 90)
                gap = $urandom_range(4, 10);
            else if (pick >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd_valid <= cv;
        op <= opv;
        dev_addr <= av;
        wr_data <= dv;
        send_ack <= ackv;
        sda_in <= sdav;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bus_step(cv, opv, av, dv, ackv, sdav, r);
        ticks_sent++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_levels_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_plan(input plan_t p);
        bus_levels_t r;
        int k;
        if (!p.is_cmd)
        begin
            for (k = 0; k < p.idle_ticks; k++)
            begin
                send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), r);
                if (p.typed)
                    r = BUS_RELEASED;
                expected_levels_q.push_back(r);
            end
        end
        else
        begin
            send_tick(1'b1, p.op, p.addr, p.data, p.ack, 1'($urandom_range(0, 1)), r);
            expected_levels_q.push_back(r);
            k = 1;
            // Commands offered while the transaction runs must be ignored.
            while (bus_phase != SEQ_IDLE)
            begin
                if (pause_mid_txn && k == 23)
                begin
                    pause_mid_txn = 1'b0;
                    hold_until_drained();
                end
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), slave_sda(p), r);
                if (r.done)
                begin
                    n_done++;
                    if (cmd_op == OP_READ)
                        n_reads++;
                    else
                        n_writes++;
                    if (r.status == STATUS_ADDR_NACK)
                        n_addr_nak++;
                    if (r.status == STATUS_DATA_NACK)
                        n_data_nak++;
                    if (p.typed)
                    begin
                        r.status = p.t_status;
                        r.rd = p.t_rd;
                    end
                end
                expected_levels_q.push_back(r);
                k++;
            end
        end
    endtask

    function automatic plan_t random_plan();
        plan_t p;
        p.is_cmd = ($urandom_range(0, 4) != 0);
        p.op = 1'($urandom_range(0, 1));
        p.addr = 8'($urandom_range(0, 255));
        p.data = 8'($urandom_range(0, 255));
        p.ack = 1'($urandom_range(0, 1));
        p.addr_nak = ($urandom_range(0, 7) == 0);
        p.data_nak = ($urandom_range(0, 7) == 0);
        p.slave_byte = 8'($urandom_range(0, 255));
        p.idle_ticks = 8'($urandom_range(1, 6));
        p.typed = 1'b0;
        p.t_status = STATUS_OK;
        p.t_rd = 8'h00;
        return p;
    endfunction

    task automatic write_delay(input logic [15:0] value);
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 65535));
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_DELAY_ADDR;
        pwdata <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        bus_delay = value;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_delay_back();
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= REG_DELAY_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[DELAY_W-1:0] !== bus_delay)
            report_mismatch("delay_ticks readback", prdata, 32'(bus_delay));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Result checker: every taken result against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        bus_levels_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_levels_q.size() == 0)
            begin
                report_mismatch("unexpected result",
                                32'({scl, sda_out, busy_res, done_res}), 32'h0);
            end
            else
            begin
                want = expected_levels_q.pop_front();
                if (scl !== want.scl)
                    report_mismatch("scl", 32'(scl), 32'(want.scl));
                if (sda_out !== want.sda)
                    report_mismatch("sda_out", 32'(sda_out), 32'(want.sda));
                if (busy_res !== want.busy)
                    report_mismatch("busy_res", 32'(busy_res), 32'(want.busy));
                if (done_res !== want.done)
                    report_mismatch("done_res", 32'(done_res), 32'(want.done));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (rd_data !== want.rd)
                    report_mismatch("rd_data", 32'(rd_data), 32'(want.rd));
            end
            results_seen++;
        end
    end

    // Receiver pacing: alternating runs of stalls and free flow, plus long
    // hold-offs on request.
    always @(posedge clk)
    begin : rx_pace
        int run_left;
        int holds_served;
        int pick;
        bit stalling;
        if (holds_served < long_hold_requests)
        begin
            holds_served++;
            stalling = 1'b1;
            run_left = LONG_HOLD_CYCLES;
        end
        else if (run_left > 0)
        begin
            run_left--;
        end
        else if (stalling)
        begin
            stalling = 1'b0;
            if ($urandom_range(0, 9) == 0)
                run_left = $urandom_range(100, 300);
            else
                run_left = $urandom_range(0, 12);
        end
        else
        begin
            stalling = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                run_left = $urandom_range(0, 2);
            else if (pick < 95)
                run_left = $urandom_range(3, 11);
            else
                run_left = $urandom_range(20, 50);
        end
        out_stall <= stalling;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results pending",
                     cycle_count, expected_levels_q.size());
            $display("i2c_master_byte_transaction_core test failed");
            $finish;
        end
    end

    initial
    begin : main_seq
        int i;
        int ph;
        int base;
        bit hold_asked;
        plan_t idle_row;
        hold_asked = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset value of the delay register, then the directed transactions.
        read_delay_back();
        write_delay(16'd1);
        read_delay_back();
        for (i = 0; i < DIRECTED_ROWS; i++)
            run_plan(directed_plan[i]);
        hold_until_drained();

        // Random transactions under a zero delay and a two-tick delay.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_delay(PHASE_DELAY[ph]);
            read_delay_back();
            base = n_done;
            if (ph == 0)
                pause_mid_txn = 1'b1;
            while (n_done - base < PHASE_TXNS[ph])
            begin
                if (ph == 1 && !hold_asked)
                begin
                    hold_asked = 1'b1;
                    long_hold_requests++;
                end
                run_plan(random_plan());
            end
            hold_until_drained();
        end

        // Largest delay: register and idle behavior only.
        write_delay(16'hFFFF);
        read_delay_back();
        idle_row = random_plan();
        idle_row.is_cmd = 1'b0;
        idle_row.idle_ticks = 8'd8;
        run_plan(idle_row);
        hold_until_drained();

        if (expected_levels_q.size() != 0)
            report_mismatch("results never arrived", 32'(expected_levels_q.size()), 32'h0);

        $display("Covered %0d requests and %0d transactions: %0d writes, %0d reads.",
                 ticks_sent, n_done, n_writes, n_reads);
        $display("Aborts: %0d address NACK, %0d data NACK; delays 5,1,0,2,65535; %0d errors.",
                 n_addr_nak, n_data_nak, error_count);
        if (error_count == 0)
            $display("i2c_master_byte_transaction_core test passed");
        else
            $display("i2c_master_byte_transaction_core test failed");
        $finish;
    end

endmodule
